// File: src/pcd_pkg.sv
// pcd_pkg: widths, command codes and sequencer states for the prefix code decoder
// no dependencies; used by prefix_code_decoder_top
package pcd_pkg;

	localparam int CODE_W    = 32;  // code bits compared per table entry
	localparam int SYM_W     = 8;
	localparam int LEN_W     = 6;   // width of a table entry length
	localparam int IDX_W     = 8;   // width of the entry_index field
	localparam int BYTE_W    = 8;
	localparam int VBITS_W   = 4;
	localparam int CFG_W     = 9;   // entries_in_use register width

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_MAX_CODE_LEN  = 32;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SCAN,
		ST_EMIT,
		ST_FLUSH,
		ST_DONE
	} state_t;

endpackage

// File: src/prefix_code_decoder_top.sv
// prefix_code_decoder_top: prefix code decoder with a loadable code table
// depends on pcd_pkg (widths, command codes, sequencer states)
//
// channel  direction  handshake             payload
// cfg      in         cfg_we                cfg_wdata (entries_in_use)
// in       in         in_valid / in_stall   command, entry_*, data_byte, valid_bits, final_byte
// out      out        out_valid / out_stall symbol, decode_error, run_last
//
// a load transaction writes the table at its accepting edge and owes no result
// a decode transaction scans n = min(entries_in_use, TABLE_ENTRIES) entries per bit,
// one per cycle through the single read port; a match ends the scan, a miss on every
// entry goes on to the next bit, and an overflow yields an error result
// the end of the byte goes through FLUSH and DONE, which may wait on out_stall
// arst_n clears the sequencer, the pending code and the register; the table keeps its contents
// in_stall is high from acceptance of a decode transaction until its last result
// has moved into the output register
module prefix_code_decoder_top #(
	parameter int TABLE_ENTRIES = pcd_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_CODE_LEN  = pcd_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [pcd_pkg::CFG_W-1:0]    cfg_wdata,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [pcd_pkg::IDX_W-1:0]    entry_index,
	input  logic [pcd_pkg::SYM_W-1:0]    entry_symbol,
	input  logic [pcd_pkg::LEN_W-1:0]    entry_length,
	input  logic [pcd_pkg::CODE_W-1:0]   entry_code,
	input  logic [pcd_pkg::BYTE_W-1:0]   data_byte,
	input  logic [pcd_pkg::VBITS_W-1:0]  valid_bits,
	input  logic                         final_byte,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pcd_pkg::SYM_W-1:0]    symbol,
	output logic                         decode_error,
	output logic                         run_last
);

	localparam int AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW     = $clog2(TABLE_ENTRIES + 1);      // scan counter, reaches n
	localparam int LW     = $clog2(MAX_CODE_LEN + 2);       // pending length, up to max + 1
	localparam int CMPW   = (LW > pcd_pkg::LEN_W) ? LW : pcd_pkg::LEN_W;
	localparam int CFG_W  = pcd_pkg::CFG_W;
	localparam int CODE_W = pcd_pkg::CODE_W;
	localparam int SYM_W  = pcd_pkg::SYM_W;
	localparam int LEN_W  = pcd_pkg::LEN_W;
	localparam int IDX_W  = pcd_pkg::IDX_W;
	localparam int BYTE_W = pcd_pkg::BYTE_W;
	localparam int VB_W   = pcd_pkg::VBITS_W;

	// code table, one write and one read port
	logic [SYM_W-1:0]  tbl_sym  [TABLE_ENTRIES];
	logic [LEN_W-1:0]  tbl_len  [TABLE_ENTRIES];
	logic [CODE_W-1:0] tbl_code [TABLE_ENTRIES];

	pcd_pkg::state_t state_q, state_nxt;

	logic [CFG_W-1:0]  entries_q;
	logic [CODE_W-1:0] pcode_q;
	logic [LW-1:0]     plen_q;
	logic [BYTE_W-1:0] byte_q;
	logic [VB_W-1:0]   nbits_q;
	logic [VB_W-1:0]   bit_cnt_q;
	logic              fin_q;

	logic [CW-1:0]     rd_idx_q;
	logic              rd_vld_s1;
	logic [SYM_W-1:0]  rd_sym_s1;
	logic [LEN_W-1:0]  rd_len_s1;
	logic [CODE_W-1:0] rd_code_s1;

	// result just found, waiting to be staged
	logic [SYM_W-1:0]  res_sym_q;
	logic              res_err_q;
	// staged result: run_last is only known once the next one shows up or the byte ends
	logic              held_vld_q;
	logic [SYM_W-1:0]  held_sym_q;
	logic              held_err_q;

	logic              out_vld_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_err_q;
	logic              out_last_q;

	logic              in_acc;
	logic              wr_en;
	logic [CW-1:0]     n_lim;
	logic [CODE_W-1:0] len_mask;
	logic              entry_hit;
	logic              out_free;
	logic              stage_ok;
	logic              flush_err;

	// sequencer outputs
	logic              do_shift;
	logic              rd_en;
	logic              hit;
	logic              scan_miss;
	logic              overflow;
	logic              take_res;
	logic              push_held;
	logic              push_last;

	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = in_acc && (command == 1'(pcd_pkg::CMD_LOAD))
	                  && ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_ENTRIES));
	assign out_free = !out_vld_q || !out_stall;
	assign stage_ok = !held_vld_q || out_free;

	// number of entries searched, capped at the table size
	assign n_lim = (entries_q > CFG_W'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : CW'(entries_q);

	// only the low 32 bits take part in the code compare
	assign len_mask = (plen_q >= LW'(CODE_W)) ? '1 : ((CODE_W'(1) << plen_q) - CODE_W'(1));

	assign entry_hit = (rd_len_s1 != '0) && (CMPW'(rd_len_s1) == CMPW'(plen_q))
	                   && (((pcode_q ^ rd_code_s1) & len_mask) == '0);

	assign overflow  = plen_q > LW'(MAX_CODE_LEN);
	assign flush_err = fin_q && (plen_q != '0);

	// table: load writes, scan reads with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_sym[entry_index[AW-1:0]]  <= entry_symbol;
			tbl_len[entry_index[AW-1:0]]  <= entry_length;
			tbl_code[entry_index[AW-1:0]] <= entry_code;
		end
		if (rd_en) begin
			rd_sym_s1  <= tbl_sym[rd_idx_q[AW-1:0]];
			rd_len_s1  <= tbl_len[rd_idx_q[AW-1:0]];
			rd_code_s1 <= tbl_code[rd_idx_q[AW-1:0]];
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pcd_pkg::ST_IDLE: begin
				if (in_acc && (command == 1'(pcd_pkg::CMD_DECODE)))
					state_nxt = pcd_pkg::ST_SHIFT;
			end
			pcd_pkg::ST_SHIFT: begin
				state_nxt = (bit_cnt_q < nbits_q) ? pcd_pkg::ST_SCAN : pcd_pkg::ST_FLUSH;
			end
			pcd_pkg::ST_SCAN: begin
				if (rd_vld_s1 && entry_hit)
					state_nxt = pcd_pkg::ST_EMIT;
				else if (!rd_vld_s1 && (rd_idx_q >= n_lim))
					state_nxt = overflow ? pcd_pkg::ST_EMIT : pcd_pkg::ST_SHIFT;
			end
			pcd_pkg::ST_EMIT: begin
				if (stage_ok)
					state_nxt = pcd_pkg::ST_SHIFT;
			end
			pcd_pkg::ST_FLUSH: begin
				if (!flush_err || stage_ok)
					state_nxt = pcd_pkg::ST_DONE;
			end
			pcd_pkg::ST_DONE: begin
				if (!held_vld_q || out_free)
					state_nxt = pcd_pkg::ST_IDLE;
			end
			default: state_nxt = pcd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		do_shift  = 1'b0;
		rd_en     = 1'b0;
		hit       = 1'b0;
		scan_miss = 1'b0;
		take_res  = 1'b0;
		push_held = 1'b0;
		push_last = 1'b0;
		case (state_q)
			pcd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			pcd_pkg::ST_SHIFT: begin
				do_shift = bit_cnt_q < nbits_q;
			end
			pcd_pkg::ST_SCAN: begin
				rd_en     = rd_idx_q < n_lim;
				hit       = rd_vld_s1 && entry_hit;
				scan_miss = !rd_vld_s1 && (rd_idx_q >= n_lim);
			end
			pcd_pkg::ST_EMIT: begin
				take_res  = stage_ok;
				push_held = stage_ok && held_vld_q;
			end
			pcd_pkg::ST_FLUSH: begin
				take_res  = flush_err && stage_ok;
				push_held = flush_err && stage_ok && held_vld_q;
			end
			pcd_pkg::ST_DONE: begin
				push_held = held_vld_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcd_pkg::ST_IDLE;
			entries_q  <= '0;
			pcode_q    <= '0;
			plen_q     <= '0;
			bit_cnt_q  <= '0;
			nbits_q    <= '0;
			fin_q      <= 1'b0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= rd_en;

			if (cfg_we)
				entries_q <= cfg_wdata;

			// capture a decode transaction; more than eight valid bits means eight
			if (in_acc && (command == 1'(pcd_pkg::CMD_DECODE))) begin
				nbits_q   <= (valid_bits > VB_W'(BYTE_W)) ? VB_W'(BYTE_W) : valid_bits;
				fin_q     <= final_byte;
				bit_cnt_q <= '0;
			end

			// append the next bit, msb first, and restart the table scan
			if (do_shift) begin
				pcode_q   <= {pcode_q[CODE_W-2:0], byte_q[BYTE_W-1]};
				plen_q    <= plen_q + LW'(1);
				bit_cnt_q <= bit_cnt_q + VB_W'(1);
				rd_idx_q  <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end

			// match, overflow or flush error at message end: the pending code starts over
			if (hit || (scan_miss && overflow) || (state_q == pcd_pkg::ST_FLUSH && take_res)) begin
				pcode_q <= '0;
				plen_q  <= '0;
			end

			if (take_res) begin
				held_vld_q <= 1'b1;
			end else if (push_held && push_last) begin
				held_vld_q <= 1'b0;
			end

			if (push_held) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc)
			byte_q <= data_byte;
		else if (do_shift)
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};

		if (hit) begin
			res_sym_q <= rd_sym_s1;
			res_err_q <= 1'b0;
		end else if (scan_miss) begin
			res_sym_q <= '0;
			res_err_q <= 1'b1;
		end

		if (take_res) begin
			held_sym_q <= (state_q == pcd_pkg::ST_FLUSH) ? '0 : res_sym_q;
			held_err_q <= (state_q == pcd_pkg::ST_FLUSH) ? 1'b1 : res_err_q;
		end

		if (push_held) begin
			out_sym_q  <= held_sym_q;
			out_err_q  <= held_err_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid    = out_vld_q;
	assign symbol       = out_sym_q;
	assign decode_error = out_err_q;
	assign run_last     = out_last_q;

	// error results carry symbol zero
	a_err_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decode_error |-> symbol == '0)
		else $error("error result with nonzero symbol");

	// pending length never runs past one bit over the longest code
	a_plen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= LW'(MAX_CODE_LEN + 1))
		else $error("pending length out of range");

	// no staged result is left behind when a new transaction may be taken
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcd_pkg::ST_IDLE |-> !held_vld_q)
		else $error("staged result left in idle");

	// a result is only moved out when the output register has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_held |-> out_free)
		else $error("result pushed into a full output register");

endmodule

// File: tb/sv/prefix_code_decoder_top_test.sv
`timescale 1ns / 1ps
// prefix_code_decoder_top_test: self-checking testbench for the prefix code decoder
// depends on pcd_pkg and prefix_code_decoder_top; decoded symbols are predicted locally
module prefix_code_decoder_top_test;

	localparam int TABLE_ENTRIES = pcd_pkg::DEF_TABLE_ENTRIES;
	localparam int MAX_CODE_LEN  = pcd_pkg::DEF_MAX_CODE_LEN;
	localparam int CODE_W        = pcd_pkg::CODE_W;
	localparam int SYM_W         = pcd_pkg::SYM_W;
	localparam int LEN_W         = pcd_pkg::LEN_W;
	localparam int IDX_W         = pcd_pkg::IDX_W;
	localparam int BYTE_W        = pcd_pkg::BYTE_W;
	localparam int VBITS_W       = pcd_pkg::VBITS_W;
	localparam int CFG_W         = pcd_pkg::CFG_W;
	localparam int VBITS_MAX     = (1 << VBITS_W) - 1;
	// watchdog bound, with generous room over the slowest legal run
	localparam int CYCLE_LIMIT   = 3_000_000;

	// one input transaction, all fields carried whatever the command
	typedef struct packed {
		pcd_pkg::cmd_t      command;
		logic [IDX_W-1:0]   entry_index;
		logic [SYM_W-1:0]   entry_symbol;
		logic [LEN_W-1:0]   entry_length;
		logic [CODE_W-1:0]  entry_code;
		logic [BYTE_W-1:0]  data_byte;
		logic [VBITS_W-1:0] valid_bits;
		logic               final_byte;
	} code_txn_t;

	// one output transaction
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             decode_error;
		logic             run_last;
	} sym_result_t;

	// dut ports, all driven inputs known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata    = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                command      = pcd_pkg::CMD_LOAD;
	logic [IDX_W-1:0]    entry_index  = '0;
	logic [SYM_W-1:0]    entry_symbol = '0;
	logic [LEN_W-1:0]    entry_length = '0;
	logic [CODE_W-1:0]   entry_code   = '0;
	logic [BYTE_W-1:0]   data_byte    = '0;
	logic [VBITS_W-1:0]  valid_bits   = '0;
	logic                final_byte   = 1'b0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [SYM_W-1:0]    symbol;
	logic                decode_error;
	logic                run_last;

	// local copy of the decoder state
	logic [SYM_W-1:0]    code_sym  [TABLE_ENTRIES];
	logic [LEN_W-1:0]    code_len  [TABLE_ENTRIES];
	logic [CODE_W-1:0]   code_bits [TABLE_ENTRIES];
	logic [CODE_W-1:0]   pend_code        = '0;
	int                  pend_len         = 0;
	logic [CFG_W-1:0]    entries_in_use_q = '0;

	// symbols and error flags still owed by the block, oldest first
	sym_result_t         expected_symbols[$];

	// idling and pressure knobs
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  hold_off_left = 0;

	// bookkeeping
	int                  fail_count  = 0;
	int                  cycle_count = 0;
	int                  n_loads     = 0;
	int                  n_bytes     = 0;
	int                  n_checked   = 0;
	int                  n_flags     = 0;
	int                  n_settings  = 0;

	prefix_code_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.entry_index  (entry_index),
		.entry_symbol (entry_symbol),
		.entry_length (entry_length),
		.entry_code   (entry_code),
		.data_byte    (data_byte),
		.valid_bits   (valid_bits),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.decode_error (decode_error),
		.run_last     (run_last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// slots searched under the current register value
	function automatic int searched_slots();
		if (entries_in_use_q > TABLE_ENTRIES)
			return TABLE_ENTRIES;
		return int'(entries_in_use_q);
	endfunction

	// lowest slot equal to the pending code in length and low bits, or -1
	function automatic int lowest_matching_slot();
		logic [CODE_W-1:0] mask;
		for (int i = 0; i < searched_slots(); i++) begin
			if (code_len[i] != 0 && int'(code_len[i]) == pend_len) begin
				mask = '1;
				if (pend_len < CODE_W)
					mask = ~({CODE_W{1'b1}} << pend_len);
				if ((pend_code & mask) == (code_bits[i] & mask))
					return i;
			end
		end
		return -1;
	endfunction

	// apply one accepted transaction and queue the results it owes
	task automatic predict_symbols(input code_txn_t t);
		sym_result_t found[$];
		sym_result_t r;
		int          nbits;
		int          slot;
		if (t.command == pcd_pkg::CMD_LOAD) begin
			code_sym[t.entry_index]  = t.entry_symbol;
			code_len[t.entry_index]  = t.entry_length;
			code_bits[t.entry_index] = t.entry_code;
			n_loads++;
			return;
		end
		n_bytes++;
		// bit counts above a byte are clipped
		nbits = (t.valid_bits > BYTE_W) ? BYTE_W : int'(t.valid_bits);
		for (int b = 0; b < nbits; b++) begin
			pend_code = {pend_code[CODE_W-2:0], t.data_byte[BYTE_W-1-b]};
			pend_len++;
			slot = lowest_matching_slot();
			if (slot >= 0) begin
				r = '{symbol: code_sym[slot], decode_error: 1'b0, run_last: 1'b0};
				found.push_back(r);
				pend_code = '0;
				pend_len  = 0;
			end else if (pend_len > MAX_CODE_LEN) begin
				// no code this long can match any more
				r = '{symbol: '0, decode_error: 1'b1, run_last: 1'b0};
				found.push_back(r);
				pend_code = '0;
				pend_len  = 0;
			end
		end
		// end of message with bits left over
		if (t.final_byte && pend_len != 0) begin
			r = '{symbol: '0, decode_error: 1'b1, run_last: 1'b0};
			found.push_back(r);
			pend_code = '0;
			pend_len  = 0;
		end
		if (found.size() > 0) begin
			r = found.pop_back();
			r.run_last = 1'b1;
			found.push_back(r);
		end
		foreach (found[i])
			expected_symbols.push_back(found[i]);
	endtask

	// ---------------------------------------------------------------
	// transaction builders
	// ---------------------------------------------------------------

	// every field random; callers overwrite what the command uses
	function automatic code_txn_t random_txn();
		code_txn_t t;
		t.command      = ($urandom_range(0, 1) == 1) ? pcd_pkg::CMD_DECODE : pcd_pkg::CMD_LOAD;
		t.entry_index  = IDX_W'($urandom());
		t.entry_symbol = SYM_W'($urandom());
		t.entry_length = LEN_W'($urandom());
		t.entry_code   = CODE_W'($urandom());
		t.data_byte    = BYTE_W'($urandom());
		t.valid_bits   = VBITS_W'($urandom());
		t.final_byte   = 1'($urandom());
		return t;
	endfunction

	function automatic code_txn_t data_txn(input logic [BYTE_W-1:0] data, input int vb,
			input logic fin);
		code_txn_t t = random_txn();
		t.command    = pcd_pkg::CMD_DECODE;
		t.data_byte  = data;
		t.valid_bits = VBITS_W'(vb);
		t.final_byte = fin;
		return t;
	endfunction

	function automatic code_txn_t load_txn(input int idx, input logic [SYM_W-1:0] sym,
			input int len, input logic [CODE_W-1:0] code);
		code_txn_t t = random_txn();
		t.command      = pcd_pkg::CMD_LOAD;
		t.entry_index  = IDX_W'(idx);
		t.entry_symbol = sym;
		t.entry_length = LEN_W'(len);
		t.entry_code   = code;
		return t;
	endfunction

	// ---------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------

	// offer one transaction; valid stays high afterwards until the next gap
	task automatic send_txn(input code_txn_t t);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		command      <= t.command;
		entry_index  <= t.entry_index;
		entry_symbol <= t.entry_symbol;
		entry_length <= t.entry_length;
		entry_code   <= t.entry_code;
		data_byte    <= t.data_byte;
		valid_bits   <= t.valid_bits;
		final_byte   <= t.final_byte;
		in_valid     <= 1'b1;
		// accepted at the first edge that sees valid without stall
		do @(posedge clk); while (in_stall);
		predict_symbols(t);
	endtask

	// sender goes quiet until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_symbols.size() != 0)
			@(posedge clk);
	endtask

	// worst time for one byte that owes nothing to finish its table scans
	function automatic int settle_cycles();
		return BYTE_W * (searched_slots() + 3) + 16;
	endfunction

	// register write, only with the block idle
	task automatic set_entries(input int value);
		wait_drained();
		while (in_stall)
			@(posedge clk);
		// a byte with no result may still be scanning
		repeat (settle_cycles()) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		entries_in_use_q = CFG_W'(value);
		n_settings++;
	endtask

	// receiver: random stalls, or a counted hold-off when a test asks for one
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// result checker: every accepted result against the oldest expectation
	initial begin
		sym_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_symbols.size() == 0) begin
					$error("unexpected result: symbol %0h decode_error %0b run_last %0b",
						symbol, decode_error, run_last);
					fail_count++;
				end else begin
					want = expected_symbols.pop_front();
					n_checked++;
					if (want.decode_error)
						n_flags++;
					if (symbol !== want.symbol) begin
						$error("symbol: expected %0h, got %0h", want.symbol, symbol);
						fail_count++;
					end
					if (decode_error !== want.decode_error) begin
						$error("decode_error: expected %0b, got %0b",
							want.decode_error, decode_error);
						fail_count++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, run_last);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("prefix_code_decoder_top_test: errors");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one well-formed message: codes of searched slots, cut into bytes of random size
	task automatic send_message();
		logic              bits[$];
		logic [BYTE_W-1:0] data;
		int                want_bits;
		int                lim;
		int                slot;
		int                len;
		int                take;
		int                vb;
		lim       = searched_slots();
		want_bits = $urandom_range(1, 40);
		while (bits.size() < want_bits) begin
			if (lim == 0) begin
				bits.push_back(1'($urandom()));
			end else begin
				slot = $urandom_range(0, lim - 1);
				len  = int'(code_len[slot]);
				if (len == MAX_CODE_LEN + 1) begin
					// only the low code bits are compared; the oldest bit is free
					bits.push_back(1'($urandom()));
					len = CODE_W;
				end
				if (len >= 1 && len <= CODE_W) begin
					for (int i = len - 1; i >= 0; i--)
						bits.push_back(code_bits[slot][i]);
				end else begin
					bits.push_back(1'($urandom()));
				end
			end
		end
		while (bits.size() > 0) begin
			take = $urandom_range(1, BYTE_W);
			if (take > bits.size())
				take = bits.size();
			// bits below the valid ones are junk on purpose
			data = BYTE_W'($urandom());
			for (int i = 0; i < take; i++)
				data[BYTE_W-1-i] = bits.pop_front();
			vb = take;
			if (take == BYTE_W && $urandom_range(0, 3) == 0)
				vb = $urandom_range(BYTE_W + 1, VBITS_MAX);
			send_txn(data_txn(data, vb, bits.size() == 0));
			// now and then an empty byte inside the message
			if (bits.size() > 0 && $urandom_range(0, 19) == 0)
				send_txn(data_txn(BYTE_W'($urandom()), 0, 1'b0));
		end
	endtask

	// junk: random bytes, random bit counts and ends, the odd table rewrite
	task automatic send_noise();
		code_txn_t t = random_txn();
		if (t.command == pcd_pkg::CMD_LOAD && $urandom_range(0, 3) != 0)
			t.command = pcd_pkg::CMD_DECODE;
		if (t.command == pcd_pkg::CMD_DECODE)
			t.final_byte = ($urandom_range(0, 3) == 0);
		send_txn(t);
	endtask

	task automatic send_traffic(input int nbytes, input int noise_pct);
		int stop_at;
		stop_at = n_bytes + nbytes;
		while (n_bytes < stop_at) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise();
			else
				send_message();
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// nothing searched: bits pile up until the overflow flag, then flushes at message end
	task automatic test_empty_table();
		set_entries(0);
		repeat (4) send_txn(data_txn(8'hFF, BYTE_W, 1'b0));
		send_txn(data_txn(8'h80, 1, 1'b0));
		send_txn(data_txn(8'hA5, 3, 1'b0));
		// no bits consumed, but the end of message still flushes
		send_txn(data_txn(8'h00, 0, 1'b1));
	endtask

	task automatic test_table_load();
		// one-bit code 0; the high code bits are ignored
		send_txn(load_txn(0, 8'h00, 1, 32'hFFFF_FFFE));
		send_txn(load_txn(1, 8'hFF, 2, 32'h0000_0002));
		// zero length never matches
		send_txn(load_txn(2, 8'h5A, 0, 32'h0000_0000));
		send_txn(load_txn(3, 8'h33, 3, 32'h0000_0006));
		// same code as slot 3, so the lower slot must win
		send_txn(load_txn(4, 8'h3C, 3, 32'h0000_0006));
		send_txn(load_txn(5, 8'h77, CODE_W, 32'hFFFF_FFFF));
		// longer than the compare width: low 32 bits and the length must agree
		send_txn(load_txn(6, 8'h99, MAX_CODE_LEN + 1, 32'hC000_0001));
		set_entries(7);
	endtask

	task automatic test_short_codes();
		send_txn(data_txn(8'h58, BYTE_W, 1'b0));
		// eight one-bit codes out of one byte
		send_txn(data_txn(8'h00, BYTE_W, 1'b0));
		// bit count above a byte is clipped
		send_txn(data_txn(8'hC0, VBITS_MAX, 1'b1));
	endtask

	// 33-bit code: 111, then zeros, then a closing one
	task automatic test_long_codes();
		send_txn(data_txn(8'hE0, BYTE_W, 1'b0));
		repeat (3) send_txn(data_txn(8'h00, BYTE_W, 1'b0));
		send_txn(data_txn(8'h80, 1, 1'b1));
	endtask

	// every slot written, so any register value is safe afterwards
	task automatic test_full_table();
		int len;
		int r;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				len = $urandom_range(1, 9);
			else if (r < 85)
				len = $urandom_range(10, CODE_W);
			else if (r < 92)
				len = MAX_CODE_LEN + 1;
			else
				len = $urandom_range(0, (1 << LEN_W) - 1);
			if (i == TABLE_ENTRIES - 1)
				len = (1 << LEN_W) - 1;
			send_txn(load_txn(i, SYM_W'($urandom()), len, CODE_W'($urandom())));
		end
	endtask

	// one idling mode: small tables, nothing searched, the wide extreme, mid-size tables
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int wide_entries);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_entries($urandom_range(1, 24));
		send_traffic(4, 15);
		set_entries(0);
		send_traffic(1, 100);
		set_entries(wide_entries);
		send_traffic(2, 20);
		set_entries($urandom_range(1, 64));
		send_traffic(4, 15);
	endtask

	// long receiver hold-off fills the block, then a full pause of the sender
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 10;
		set_entries($urandom_range(2, 12));
		hold_off_left = 400;
		send_traffic(6, 0);
		wait_drained();
		send_traffic(2, 10);
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 60;
		test_empty_table();
		test_table_load();
		test_short_codes();
		test_long_codes();
		test_full_table();

		test_random_traffic(22, 60, TABLE_ENTRIES);
		test_random_traffic(60, 22, (1 << CFG_W) - 1);
		test_random_traffic(0, 0, $urandom_range(TABLE_ENTRIES + 1, (1 << CFG_W) - 1));
		test_backpressure();

		// nothing owed any more; give stray results time to show up
		wait_drained();
		repeat (settle_cycles()) @(posedge clk);

		$display("covered %0d table loads and %0d data bytes over %0d register settings",
			n_loads, n_bytes, n_settings);
		$display("%0d results checked, %0d of them error flags, %0d mismatches",
			n_checked, n_flags, fail_count);
		if (fail_count == 0)
			$display("prefix_code_decoder_top_test: clean");
		else
			$display("prefix_code_decoder_top_test: errors");
		$finish;
	end

endmodule

// File: sim.f
src/pcd_pkg.sv
src/prefix_code_decoder_top.sv
tb/sv/prefix_code_decoder_top_test.sv
